// ===== rtl/core/pdfu_pkg.sv =====
// ----------------------------------------------------------------------------
// pdfu_pkg
// Shared types, constants and helpers of the PDF string decoder.
// ----------------------------------------------------------------------------
package pdfu_pkg;

  localparam int MAX_NEST_DEPTH = 255;
  localparam int DEPTH_W        = $clog2(MAX_NEST_DEPTH + 1);

  // result queue between decoder and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE     = 3'd0,
    M_LIT      = 3'd1,
    M_ESC      = 3'd2,
    M_CRCONT   = 3'd3,
    M_OCT      = 3'd4,
    M_HEXSTART = 3'd5,
    M_HEX      = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } res_t;

  // results of one input byte: one or two
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b1, c[3:0] + 4'd9};
    return v;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

endpackage

// ===== rtl/core/pdf_string_unescaper.sv =====
// ----------------------------------------------------------------------------
// pdf_string_unescaper
// Streams decoded bytes of one PDF literal or hex string, then done/failed.
// ----------------------------------------------------------------------------
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid in_stall in_data_byte in_first_byte    | in
//          | in_final_byte                                   |
//  result  | out_valid out_stall out_byte out_kind           | out
//          | out_last_of_run                                 |
//
// One raw byte per cycle is taken while the four-entry result queue has room.
// Results leave the output register one per cycle while out_stall is low; a
// byte with two results sends them in turn over the single output port.
// The first result passes through the queue, then the output register.
// Reset empties the queue and returns the decoder to idle; no clearing pass.
// A stalled output fills the queue, which then stalls the input side.
// ----------------------------------------------------------------------------
module pdf_string_unescaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last_of_run
);
  import pdfu_pkg::*;

  logic    accept, push, pop;
  op_t     push_op, head_op;
  q_stat_t stat;

  assign in_stall = stat.full;
  assign accept   = in_valid && !stat.full;

  pdfu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .first_byte (in_first_byte),
    .final_byte (in_final_byte),
    .push       (push),
    .op         (push_op)
  );

  pdfu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .stat    (stat)
  );

  pdfu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_op         (head_op),
    .stat            (stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== rtl/core/pdfu_front.sv =====
// ----------------------------------------------------------------------------
// pdfu_front
// Decoder: takes one raw byte per transfer, updates the parse state and
// emits that byte's results, if any (one or two), as a single queue entry.
// ----------------------------------------------------------------------------
module pdfu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          first_byte,
  input  logic          final_byte,
  output logic          push,
  output pdfu_pkg::op_t op
);
  import pdfu_pkg::*;

  mode_t               mode_r, mode_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [7:0]          acc_r, acc_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [3:0]          hi_r, hi_nxt;
  logic                pend_r, pend_nxt;

  res_t       res [2];
  logic [1:0] n;
  logic       do_lit, do_hex, clr;
  logic [4:0] hv;
  logic [7:0] c;

  assign c  = data_byte;
  assign hv = hex_val(data_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      depth_r <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      hi_r    <= '0;
      pend_r  <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      hi_r    <= hi_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    hi_nxt    = hi_r;
    pend_nxt  = pend_r;
    res[0]    = '{data: 8'h00, kind: KIND_DATA};
    res[1]    = '{data: 8'h00, kind: KIND_DATA};
    n         = 2'd0;
    do_lit    = 1'b0;
    do_hex    = 1'b0;
    clr       = 1'b0;

    if (first_byte) begin
      clr = 1'b1;
      if (c == CH_LPAREN) begin
        mode_nxt = M_LIT;
      end else if (c == CH_LT) begin
        mode_nxt = M_HEXSTART;
      end else begin
        res[n[0]] = '{data: 8'h00, kind: KIND_FAIL};
        n         = n + 2'd1;
        mode_nxt  = M_IDLE;
      end
    end else begin
      case (mode_r)
        M_LIT: do_lit = 1'b1;
        M_ESC: begin
          mode_nxt = M_LIT;
          case (c)
            CH_N: begin res[n[0]] = '{data: CH_LF,  kind: KIND_DATA}; n = n + 2'd1; end
            CH_R: begin res[n[0]] = '{data: CH_CR,  kind: KIND_DATA}; n = n + 2'd1; end
            CH_T: begin res[n[0]] = '{data: CH_TAB, kind: KIND_DATA}; n = n + 2'd1; end
            CH_B: begin res[n[0]] = '{data: CH_BS,  kind: KIND_DATA}; n = n + 2'd1; end
            CH_F: begin res[n[0]] = '{data: CH_FF,  kind: KIND_DATA}; n = n + 2'd1; end
            CH_CR: mode_nxt = M_CRCONT;
            CH_LF: ;
            default: begin
              if (is_oct(c)) begin
                acc_nxt  = {5'd0, c[2:0]};
                cnt_nxt  = 2'd1;
                mode_nxt = M_OCT;
              end else begin
                res[n[0]] = '{data: c, kind: KIND_DATA};
                n         = n + 2'd1;
              end
            end
          endcase
        end
        M_CRCONT: begin
          mode_nxt = M_LIT;
          do_lit   = (c != CH_LF);
        end
        M_OCT: begin
          if (is_oct(c) && cnt_r != 2'd3) begin
            acc_nxt = {acc_r[4:0], c[2:0]};
            cnt_nxt = cnt_r + 2'd1;
            if (cnt_r == 2'd2) begin
              res[n[0]] = '{data: {acc_r[4:0], c[2:0]}, kind: KIND_DATA};
              n         = n + 2'd1;
              acc_nxt   = '0;
              cnt_nxt   = '0;
              mode_nxt  = M_LIT;
            end
          end else begin
            res[n[0]] = '{data: acc_r, kind: KIND_DATA};
            n         = n + 2'd1;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            mode_nxt  = M_LIT;
            do_lit    = 1'b1;
          end
        end
        M_HEXSTART: begin
          if (c == CH_LT) begin
            // dictionary open, not a string
            res[n[0]] = '{data: 8'h00, kind: KIND_FAIL};
            n         = n + 2'd1;
            mode_nxt  = M_IDLE;
            clr       = 1'b1;
          end else begin
            do_hex = 1'b1;
          end
        end
        M_HEX:   do_hex = 1'b1;
        default: mode_nxt = M_IDLE;
      endcase
    end

    if (do_lit) begin
      if (c == CH_BSLASH) begin
        mode_nxt = M_ESC;
      end else if (c == CH_LPAREN) begin
        if (depth_r >= DEPTH_W'(MAX_NEST_DEPTH)) begin
          res[n[0]] = '{data: 8'h00, kind: KIND_FAIL};
          n         = n + 2'd1;
          mode_nxt  = M_IDLE;
          clr       = 1'b1;
        end else begin
          depth_nxt = depth_r + DEPTH_W'(1);
          res[n[0]] = '{data: c, kind: KIND_DATA};
          n         = n + 2'd1;
        end
      end else if (c == CH_RPAREN) begin
        if (depth_r == '0) begin
          res[n[0]] = '{data: 8'h00, kind: KIND_DONE};
          n         = n + 2'd1;
          mode_nxt  = M_IDLE;
          clr       = 1'b1;
        end else begin
          depth_nxt = depth_r - DEPTH_W'(1);
          res[n[0]] = '{data: c, kind: KIND_DATA};
          n         = n + 2'd1;
        end
      end else begin
        res[n[0]] = '{data: c, kind: KIND_DATA};
        n         = n + 2'd1;
      end
    end

    if (do_hex) begin
      mode_nxt = M_HEX;
      if (c == CH_GT) begin
        // odd final nibble is padded with zero
        if (pend_r) begin
          res[n[0]] = '{data: {hi_r, 4'h0}, kind: KIND_DATA};
          n         = n + 2'd1;
        end
        res[n[0]] = '{data: 8'h00, kind: KIND_DONE};
        n         = n + 2'd1;
        mode_nxt  = M_IDLE;
        clr       = 1'b1;
      end else if (hv[4]) begin
        if (pend_r) begin
          res[n[0]] = '{data: {hi_r, hv[3:0]}, kind: KIND_DATA};
          n         = n + 2'd1;
          pend_nxt  = 1'b0;
          hi_nxt    = '0;
        end else begin
          hi_nxt   = hv[3:0];
          pend_nxt = 1'b1;
        end
      end
    end

    // buffer ran out with the string still open: only a failure goes out
    if (final_byte && mode_nxt != M_IDLE) begin
      res[0]   = '{data: 8'h00, kind: KIND_FAIL};
      n        = 2'd1;
      mode_nxt = M_IDLE;
      clr      = 1'b1;
    end

    if (clr) begin
      depth_nxt = '0;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      hi_nxt    = '0;
      pend_nxt  = 1'b0;
    end
  end

  assign push   = accept && (n != 2'd0);
  assign op.r0  = res[0];
  assign op.r1  = res[1];
  assign op.two = (n == 2'd2);

endmodule

// ===== rtl/core/pdfu_queue.sv =====
// ----------------------------------------------------------------------------
// pdfu_queue
// Short FIFO of result entries between the decoder and the output stage.
// ----------------------------------------------------------------------------
module pdfu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pdfu_pkg::op_t     push_op,
  input  logic              pop,
  output pdfu_pkg::op_t     head_op,
  output pdfu_pkg::q_stat_t stat
);
  import pdfu_pkg::*;

  op_t           mem [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QAW'(1);
      if (pop)  rptr_r <= rptr_r + QAW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QAW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QAW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign head_op    = mem[rptr_r];
  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== rtl/core/pdfu_back.sv =====
// ----------------------------------------------------------------------------
// pdfu_back
// Output stage: splits queue entries into single results and holds each
// one in the output register until it is transferred.
// ----------------------------------------------------------------------------
module pdfu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pdfu_pkg::op_t     head_op,
  input  pdfu_pkg::q_stat_t stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_kind,
  output logic              out_last_of_run
);
  import pdfu_pkg::*;

  logic  vld_r, vld_nxt;
  res_t  res_r, res_nxt;
  logic  last_r, last_nxt;
  logic  sec_r, sec_nxt;   // second result of the last popped entry waits
  res_t  sec_res_r, sec_res_nxt;
  logic  load;

  assign load = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sec_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sec_r <= sec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    last_r    <= last_nxt;
    sec_res_r <= sec_res_nxt;
  end

  always_comb begin
    vld_nxt     = vld_r;
    res_nxt     = res_r;
    last_nxt    = last_r;
    sec_nxt     = sec_r;
    sec_res_nxt = sec_res_r;
    pop         = 1'b0;
    if (load) begin
      if (sec_r) begin
        vld_nxt  = 1'b1;
        res_nxt  = sec_res_r;
        last_nxt = 1'b1;
        sec_nxt  = 1'b0;
      end else if (!stat.empty) begin
        pop         = 1'b1;
        vld_nxt     = 1'b1;
        res_nxt     = head_op.r0;
        last_nxt    = !head_op.two;
        sec_nxt     = head_op.two;
        sec_res_nxt = head_op.r1;
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  assign out_valid       = vld_r;
  assign out_byte        = res_r.data;
  assign out_kind        = res_r.kind;
  assign out_last_of_run = last_r;

endmodule

// ===== rtl/core/pdfu_checker.sv =====
// ----------------------------------------------------------------------------
// pdfu_checker
// Port-level checks of the PDF string decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pdfu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_last_of_run
);
  import pdfu_pkg::*;

  // a result kind is always one of data, done, failed
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_DONE ||
                   out_kind == KIND_FAIL))
    else $error("illegal result kind");

  // done/failed carry a zero byte and always close the run
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> (out_byte == 8'h00 && out_last_of_run))
    else $error("status result with data or not last");

  // first of two results is a data byte and the second one follows at once
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_of_run) |->
      (out_kind == KIND_DATA) ##1 out_valid)
    else $error("second result of a byte missing");

  // held result does not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_byte) && $stable(out_kind) && $stable(out_last_of_run)))
    else $error("stalled result changed");

endmodule

bind pdf_string_unescaper pdfu_checker u_pdfu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_kind        (out_kind),
  .out_last_of_run (out_last_of_run)
);

// ===== verif/pdf_string_unescaper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pdf_string_unescaper. A directed table of bytes comes
// first, then randomized literal and hex strings with noise and truncations.
// Every accepted byte runs through a behavioral decoder; its expected results
// (a typed row's own instead) are queued and compared field by field on accept.
// ----------------------------------------------------------------------------
module testbench;
  import pdfu_pkg::*;

  localparam int DIR_N     = 28;
  localparam int ITEMS     = 1650;
  localparam int HOLD_CYC  = 300;
  localparam int IDLE_PCT  = 11;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } dec_res_t;

  // one input byte; typed rows carry their expected results
  typedef struct packed {
    logic [7:0] c;
    logic       first;
    logic       fin;
    logic       typed;
    logic [1:0] n_exp;
    logic [7:0] d0;
    kind_t      k0;
    logic [7:0] d1;
    kind_t      k1;
  } stim_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_first_byte = 1'b0;
  logic       in_final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last_of_run;

  pdf_string_unescaper uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_first_byte  (in_first_byte),
    .in_final_byte  (in_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_last_of_run(out_last_of_run)
  );

  always #10 clk = ~clk;

  stim_t dir_tab [DIR_N] = '{
    '{8'hFF, 1'b0, 1'b0, 1'b1, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},  // stray
    '{8'h00, 1'b1, 1'b0, 1'b1, 2'd1, 8'h00, KIND_FAIL, 8'h00, KIND_DATA},  // bad first
    '{8'h28, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h5C, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h6E, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h5C, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h30, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h31, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h37, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},  // 3rd digit
    '{8'h5C, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h37, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h41, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},  // ends octal
    '{8'h5C, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h0D, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h0A, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h29, 1'b0, 1'b1, 1'b1, 2'd1, 8'h00, KIND_DONE, 8'h00, KIND_DATA},  // close+final
    '{8'h3C, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h3C, 1'b0, 1'b0, 1'b1, 2'd1, 8'h00, KIND_FAIL, 8'h00, KIND_DATA},  // dictionary
    '{8'h3C, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h61, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h20, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h46, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h31, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h3E, 1'b0, 1'b0, 1'b1, 2'd2, 8'h10, KIND_DATA, 8'h00, KIND_DONE},  // odd pad
    '{8'h28, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},
    '{8'h3C, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, KIND_DATA, 8'h00, KIND_DATA},  // restart
    '{8'h79, 1'b0, 1'b1, 1'b1, 2'd1, 8'h00, KIND_FAIL, 8'h00, KIND_DATA}   // unclosed
  };

  stim_t    stim_q[$];
  dec_res_t decoded_q[$];
  dec_res_t step_res[$];
  int       errors = 0;
  int       got_cnt = 0;

  // decoder state
  mode_t       dmode = M_IDLE;
  int unsigned depth = 0;
  logic [7:0]  oct_acc = 8'h00;
  int          oct_cnt = 0;
  logic [3:0]  hi_nib = 4'h0;
  logic        nib_pend = 1'b0;

  function automatic void emit(input logic [7:0] d, input kind_t k);
    dec_res_t r;
    r.data = d;
    r.kind = k;
    r.last = 1'b0;
    step_res = {step_res, r};
  endfunction

  function automatic void clear_dec();
    depth = 0;
    oct_acc = 8'h00;
    oct_cnt = 0;
    hi_nib = 4'h0;
    nib_pend = 1'b0;
  endfunction

  function automatic void abort_dec();
    emit(8'h00, KIND_FAIL);
    dmode = M_IDLE;
    clear_dec();
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    return -1;
  endfunction

  function automatic void lit_char(input logic [7:0] c);
    if (c == CH_BSLASH) begin
      dmode = M_ESC;
    end else if (c == CH_LPAREN) begin
      if (depth >= MAX_NEST_DEPTH) begin
        abort_dec();
      end else begin
        depth++;
        emit(c, KIND_DATA);
      end
    end else if (c == CH_RPAREN) begin
      if (depth == 0) begin
        emit(8'h00, KIND_DONE);
        dmode = M_IDLE;
        clear_dec();
      end else begin
        depth--;
        emit(c, KIND_DATA);
      end
    end else begin
      emit(c, KIND_DATA);
    end
  endfunction

  function automatic void esc_char(input logic [7:0] c);
    dmode = M_LIT;
    case (c)
      CH_N:  emit(CH_LF, KIND_DATA);
      CH_R:  emit(CH_CR, KIND_DATA);
      CH_T:  emit(CH_TAB, KIND_DATA);
      CH_B:  emit(CH_BS, KIND_DATA);
      CH_F:  emit(CH_FF, KIND_DATA);
      CH_CR: dmode = M_CRCONT;
      CH_LF: ;
      default: begin
        if (c >= 8'h30 && c <= 8'h37) begin
          oct_acc = {5'd0, c[2:0]};
          oct_cnt = 1;
          dmode = M_OCT;
        end else begin
          emit(c, KIND_DATA);
        end
      end
    endcase
  endfunction

  function automatic void hex_char(input logic [7:0] c);
    int v;
    dmode = M_HEX;
    if (c == CH_GT) begin
      if (nib_pend) emit({hi_nib, 4'h0}, KIND_DATA);
      emit(8'h00, KIND_DONE);
      dmode = M_IDLE;
      clear_dec();
    end else begin
      v = hex_digit(c);
      if (v >= 0) begin
        if (nib_pend) begin
          emit({hi_nib, v[3:0]}, KIND_DATA);
          nib_pend = 1'b0;
          hi_nib = 4'h0;
        end else begin
          hi_nib = v[3:0];
          nib_pend = 1'b1;
        end
      end
    end
  endfunction

  // results of one accepted byte land in step_res
  function automatic void decode_byte(input logic [7:0] c, input logic first,
                                      input logic fin);
    step_res.delete();
    if (first) begin
      clear_dec();
      if (c == CH_LPAREN) dmode = M_LIT;
      else if (c == CH_LT) dmode = M_HEXSTART;
      else abort_dec();
    end else begin
      case (dmode)
        M_LIT: lit_char(c);
        M_ESC: esc_char(c);
        M_CRCONT: begin
          dmode = M_LIT;
          if (c != CH_LF) lit_char(c);
        end
        M_OCT: begin
          if (c >= 8'h30 && c <= 8'h37) begin
            oct_acc = (oct_acc << 3) + {5'd0, c[2:0]};
            oct_cnt++;
            if (oct_cnt >= 3) begin
              emit(oct_acc, KIND_DATA);
              oct_acc = 8'h00;
              oct_cnt = 0;
              dmode = M_LIT;
            end
          end else begin
            // value goes out first, then the byte is a plain literal byte
            emit(oct_acc, KIND_DATA);
            oct_acc = 8'h00;
            oct_cnt = 0;
            dmode = M_LIT;
            lit_char(c);
          end
        end
        M_HEXSTART: begin
          if (c == CH_LT) abort_dec();
          else hex_char(c);
        end
        M_HEX: hex_char(c);
        default: dmode = M_IDLE;
      endcase
    end
    // still open at end of buffer: only the failure is reported
    if (fin && dmode != M_IDLE) begin
      step_res.delete();
      abort_dec();
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             got_cnt, what, got, want);
  endtask

  // ---------------- stimulus generation ----------------
  task automatic add(input logic [7:0] c, input logic first, input logic fin);
    stim_t s;
    s = '0;
    s.c = c;
    s.first = first;
    s.fin = fin;
    stim_q = {stim_q, s};
  endtask

  task automatic gen_literal(input bit broken);
    string esc_set;
    int len, lvl, i;
    logic [7:0] c;
    bit fin_end;
    esc_set = "nrtbf()\\";
    lvl = 0;
    add(CH_LPAREN, 1'b1, 1'b0);
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
    repeat (len) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          c = 8'($urandom_range(255));
          if (c == CH_BSLASH || c == CH_LPAREN || c == CH_RPAREN) c = 8'h2E;
          add(c, 1'b0, 1'b0);
        end
        3: begin
          add(CH_LPAREN, 1'b0, 1'b0);
          lvl++;
        end
        4: begin
          if (lvl > 0) begin
            add(CH_RPAREN, 1'b0, 1'b0);
            lvl--;
          end
        end
        5: begin
          add(CH_BSLASH, 1'b0, 1'b0);
          add(esc_set[$urandom_range(7)], 1'b0, 1'b0);
        end
        6: begin
          add(CH_BSLASH, 1'b0, 1'b0);
          repeat ($urandom_range(1, 3))
            add(8'h30 + 8'($urandom_range(7)), 1'b0, 1'b0);
        end
        7: begin
          add(CH_BSLASH, 1'b0, 1'b0);
          case ($urandom_range(2))
            0: add(CH_CR, 1'b0, 1'b0);
            1: add(CH_LF, 1'b0, 1'b0);
            default: begin
              add(CH_CR, 1'b0, 1'b0);
              add(CH_LF, 1'b0, 1'b0);
            end
          endcase
        end
        8: begin
          add(CH_BSLASH, 1'b0, 1'b0);
          add(8'($urandom_range(255)), 1'b0, 1'b0);
        end
        default: add($urandom_range(1) ? CH_CR : CH_LF, 1'b0, 1'b0);
      endcase
    end
    if (broken) begin
      // either runs out of buffer or gets cut off by the next first byte
      if ($urandom_range(1)) add(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      fin_end = ($urandom_range(3) == 0);
      for (i = 0; i <= lvl; i++) add(CH_RPAREN, 1'b0, fin_end && i == lvl);
    end
  endtask

  task automatic gen_hex(input bit broken);
    string hex_set;
    int len;
    logic [7:0] c;
    hex_set = "0123456789abcdefABCDEF";
    add(CH_LT, 1'b1, 1'b0);
    if ($urandom_range(11) == 0) begin
      add(CH_LT, 1'b0, 1'($urandom_range(1)));
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
      repeat (len) begin
        case ($urandom_range(9))
          0: add($urandom_range(1) ? 8'h20 : CH_LF, 1'b0, 1'b0);
          1: begin
            c = 8'($urandom_range(255));
            if (c == CH_GT) c = 8'h00;
            add(c, 1'b0, 1'b0);
          end
          default: add(hex_set[$urandom_range(21)], 1'b0, 1'b0);
        endcase
      end
      if (broken) begin
        if ($urandom_range(1)) add(hex_set[$urandom_range(21)], 1'b0, 1'b1);
      end else begin
        add(CH_GT, 1'b0, $urandom_range(3) == 0);
      end
    end
  endtask

  task automatic build_random();
    int r;
    // climb to the nesting bound; the last '(' must fail
    add(CH_LPAREN, 1'b1, 1'b0);
    repeat (MAX_NEST_DEPTH + 1) add(CH_LPAREN, 1'b0, 1'b0);
    while (stim_q.size() < ITEMS) begin
      r = $urandom_range(99);
      if (r < 45) begin
        gen_literal(r < 5);
      end else if (r < 85) begin
        gen_hex(r < 49);
      end else begin
        repeat ($urandom_range(1, 6))
          add(8'($urandom_range(255)), $urandom_range(9) == 0, $urandom_range(15) == 0);
      end
    end
  endtask

  // ---------------- input side ----------------
  task automatic send_byte(input stim_t s, input bit drain, input bit calm);
    dec_res_t r;
    int k;
    if (drain) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (decoded_q.size() != 0) @(posedge clk);
    end
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= s.c;
    in_first_byte <= s.first;
    in_final_byte <= s.fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer done at this edge
    decode_byte(s.c, s.first, s.fin);
    if (s.typed) begin
      for (k = 0; k < int'(s.n_exp); k++) begin
        r.data = (k == 0) ? s.d0 : s.d1;
        r.kind = (k == 0) ? s.k0 : s.k1;
        r.last = (k == int'(s.n_exp) - 1);
        decoded_q = {decoded_q, r};
      end
    end else begin
      foreach (step_res[j]) decoded_q = {decoded_q, step_res[j]};
    end
  endtask

  initial begin : stimulus
    int i;
    foreach (dir_tab[j]) stim_q = {stim_q, dir_tab[j]};
    build_random();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < stim_q.size(); i++)
      send_byte(stim_q[i], i == DIR_N || i % 500 == 0, i >= 900 && i < 1150);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[pdf_string_unescaper] OK");
    end else begin
      $display("[pdf_string_unescaper] ERROR");
    end
    $finish;
  end

  // ---------------- result side ----------------
  initial begin : sink_stall
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && got_cnt >= 300) begin
        // long hold-off so the queue fills and backs up into the input
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
      end
      if (got_cnt >= 600 && got_cnt < 900) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    dec_res_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got_cnt++;
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing pending, out_byte", int'(out_byte), 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", int'(out_byte), int'(want.data));
        if (out_kind !== want.kind)
          report_mismatch("out_kind", int'(out_kind), int'(want.kind));
        if (out_last_of_run !== want.last)
          report_mismatch("out_last_of_run", int'(out_last_of_run), int'(want.last));
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("[pdf_string_unescaper] ERROR");
    $finish;
  end

endmodule
